### src/mre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_pkg
// Shared opcodes, status codes, field widths and the command and status
// structures between the event ring controller and its datapath.
// ----------------------------------------------------------------------------
package mre_pkg;

    localparam int OPCODE_W = 2;
    localparam int TYPE_W   = 5;
    localparam int WORD_W   = 32;
    localparam int SUBIDX_W = 4;
    localparam int SEQ_W    = 64;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_PUBLISH   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SUBSCRIBE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POLL      = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_PENDING   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic load;
        logic publish;
        logic subscribe;
        logic reject;
        logic scan_init;
        logic scan;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                idx_ok;
        logic                scan_done;
        logic                out_free;
    } t_dp_stat;

endpackage

### src/mre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_ctrl
// Controller state machine: accepts a transaction, sequences the operation
// through the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module mre_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mre_pkg::t_dp_stat i_stat,
    output mre_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.op)
                    mre_pkg::OP_PUBLISH: begin
                        o_cmd.publish = 1'b1;
                        n_state       = S_RESULT;
                    end
                    mre_pkg::OP_SUBSCRIBE: begin
                        o_cmd.subscribe = 1'b1;
                        n_state         = S_RESULT;
                    end
                    default: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end else begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_RESULT;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### src/mre_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_dp
// Datapath: event ring memory, reader table memory, sequence counter,
// slot scan with a registered read pipeline, result and output registers.
// ----------------------------------------------------------------------------
module mre_dp #(
    parameter int RING_DEPTH      = 128,
    parameter int MAX_SUBSCRIBERS = 16,
    parameter int PAYLOAD_BITS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mre_pkg::t_dp_cmd                    i_cmd,
    output mre_pkg::t_dp_stat                   o_stat,
    input  logic [mre_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic [mre_pkg::TYPE_W-1:0]          i_pub_type,
    input  logic [mre_pkg::WORD_W-1:0]          i_pub_payload,
    input  logic [mre_pkg::WORD_W-1:0]          i_filter_mask,
    input  logic [mre_pkg::SUBIDX_W-1:0]        i_sub_index,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [mre_pkg::STATUS_W-1:0]        o_status,
    output logic [mre_pkg::SEQ_W-1:0]           o_assigned_seq,
    output logic [mre_pkg::SUBIDX_W-1:0]        o_assigned_sub,
    output logic [mre_pkg::TYPE_W-1:0]          o_got_type,
    output logic [mre_pkg::WORD_W-1:0]          o_got_payload,
    output logic [mre_pkg::COUNT_W-1:0]         o_match_count
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int PW  = FW + 1;
    localparam int SAW = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
    localparam int STW = $clog2(MAX_SUBSCRIBERS + 1);
    localparam int CW  = (STW > mre_pkg::SUBIDX_W) ? STW : mre_pkg::SUBIDX_W;

    // Event ring and reader table storage.
    logic [mre_pkg::TYPE_W-1:0] ring_types    [RING_DEPTH];
    logic [PAYLOAD_BITS-1:0]    ring_payloads [RING_DEPTH];
    logic [mre_pkg::SEQ_W-1:0]  ring_seqs     [RING_DEPTH];
    logic [mre_pkg::WORD_W-1:0] sub_masks     [MAX_SUBSCRIBERS];
    logic [mre_pkg::SEQ_W-1:0]  sub_cursors   [MAX_SUBSCRIBERS];

    // Latched transaction.
    logic [mre_pkg::OPCODE_W-1:0] r_op;
    logic [mre_pkg::TYPE_W-1:0]   r_type;
    logic [mre_pkg::WORD_W-1:0]   r_payload;
    logic [mre_pkg::WORD_W-1:0]   r_mask;
    logic [mre_pkg::SUBIDX_W-1:0] r_idx;

    // Ring and reader bookkeeping.
    logic [AW-1:0]              r_oldest;
    logic [FW-1:0]              r_fill;
    logic [mre_pkg::SEQ_W-1:0]  r_seq;
    logic [STW-1:0]             r_sub_total;

    // Scan state.
    logic [AW-1:0]              r_scan_slot;
    logic [FW-1:0]              r_scan_cnt;
    logic                       r_rd_vld;
    logic [mre_pkg::TYPE_W-1:0] r_rd_type;
    logic [PAYLOAD_BITS-1:0]    r_rd_pay;
    logic [mre_pkg::SEQ_W-1:0]  r_rd_seq;
    logic [mre_pkg::WORD_W-1:0] r_sub_mask;
    logic [mre_pkg::SEQ_W-1:0]  r_sub_cursor;

    // Result and output registers.
    logic [mre_pkg::STATUS_W-1:0] r_res_status;
    logic [mre_pkg::SEQ_W-1:0]    r_res_seq;
    logic [mre_pkg::SUBIDX_W-1:0] r_res_sub;
    logic [mre_pkg::TYPE_W-1:0]   r_res_type;
    logic [mre_pkg::WORD_W-1:0]   r_res_pay;
    logic [mre_pkg::COUNT_W-1:0]  r_res_cnt;
    logic                         r_o_valid;
    logic [mre_pkg::STATUS_W-1:0] r_o_status;
    logic [mre_pkg::SEQ_W-1:0]    r_o_seq;
    logic [mre_pkg::SUBIDX_W-1:0] r_o_sub;
    logic [mre_pkg::TYPE_W-1:0]   r_o_type;
    logic [mre_pkg::WORD_W-1:0]   r_o_pay;
    logic [mre_pkg::COUNT_W-1:0]  r_o_cnt;

    logic [PW-1:0]              w_pub_sum;
    logic [AW-1:0]              w_pub_slot;
    logic                       w_ring_full;
    logic                       w_sub_full;
    logic [SAW-1:0]             w_sub_addr;
    logic [SAW-1:0]             w_new_addr;
    logic                       w_idx_ok;
    logic                       w_is_poll;
    logic                       w_issue;
    logic                       w_hit;
    logic                       w_poll_hit;
    logic                       w_out_free;
    logic                       w_cur_we;
    logic [SAW-1:0]             w_cur_addr;
    logic [mre_pkg::SEQ_W-1:0]  w_cur_data;

    assign w_pub_sum   = PW'(r_oldest) + PW'(r_fill);
    assign w_pub_slot  = (w_pub_sum >= PW'(RING_DEPTH)) ? AW'(w_pub_sum - PW'(RING_DEPTH))
                                                        : AW'(w_pub_sum);
    assign w_ring_full = (r_fill == FW'(RING_DEPTH));
    assign w_sub_full  = (r_sub_total >= STW'(MAX_SUBSCRIBERS));
    assign w_sub_addr  = SAW'(CW'(r_idx));
    assign w_new_addr  = SAW'(r_sub_total);
    assign w_idx_ok    = (CW'(r_idx) < CW'(r_sub_total));
    assign w_is_poll   = (r_op == mre_pkg::OP_POLL);
    assign w_issue     = i_cmd.scan && (r_scan_cnt != r_fill);
    assign w_hit       = r_rd_vld && (r_rd_seq > r_sub_cursor) && r_sub_mask[r_rd_type];
    assign w_poll_hit  = i_cmd.scan && w_hit && w_is_poll;
    assign w_out_free  = !r_o_valid || i_out_ready;

    assign w_cur_we   = (i_cmd.subscribe && !w_sub_full) || w_poll_hit;
    assign w_cur_addr = i_cmd.subscribe ? w_new_addr : w_sub_addr;
    assign w_cur_data = i_cmd.subscribe ? '0 : r_rd_seq;

    assign o_stat.op        = r_op;
    assign o_stat.idx_ok    = w_idx_ok;
    assign o_stat.scan_done = (w_hit && w_is_poll) || ((r_scan_cnt == r_fill) && !r_rd_vld);
    assign o_stat.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_opcode;
            r_type    <= i_pub_type;
            r_payload <= i_pub_payload;
            r_mask    <= i_filter_mask;
            r_idx     <= i_sub_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_fill      <= '0;
            r_seq       <= 64'd1;
            r_sub_total <= '0;
        end else begin
            if (i_cmd.publish) begin
                r_seq <= r_seq + 64'd1;
                if (w_ring_full) begin
                    r_oldest <= (r_oldest == AW'(RING_DEPTH - 1)) ? '0 : r_oldest + AW'(1);
                end else begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            if (i_cmd.subscribe && !w_sub_full) begin
                r_sub_total <= r_sub_total + STW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            ring_types[w_pub_slot]    <= r_type;
            ring_payloads[w_pub_slot] <= PAYLOAD_BITS'(r_payload);
            ring_seqs[w_pub_slot]     <= r_seq;
        end
        if (w_issue) begin
            r_rd_type <= ring_types[r_scan_slot];
            r_rd_pay  <= ring_payloads[r_scan_slot];
            r_rd_seq  <= ring_seqs[r_scan_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.subscribe && !w_sub_full) begin
            sub_masks[w_new_addr] <= r_mask;
        end
        if (w_cur_we) begin
            sub_cursors[w_cur_addr] <= w_cur_data;
        end
        if (i_cmd.scan_init) begin
            r_sub_mask   <= sub_masks[w_sub_addr];
            r_sub_cursor <= sub_cursors[w_sub_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_slot <= r_oldest;
            r_scan_cnt  <= '0;
        end else if (w_issue) begin
            r_scan_slot <= (r_scan_slot == AW'(RING_DEPTH - 1)) ? '0 : r_scan_slot + AW'(1);
            r_scan_cnt  <= r_scan_cnt + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_status <= mre_pkg::ST_DONE;
            r_res_seq    <= '0;
            r_res_sub    <= '0;
            r_res_type   <= '0;
            r_res_pay    <= '0;
            r_res_cnt    <= '0;
        end
        if (i_cmd.publish) begin
            r_res_seq <= r_seq;
        end
        if (i_cmd.subscribe) begin
            if (w_sub_full) begin
                r_res_status <= mre_pkg::ST_REJECTED;
            end else begin
                r_res_sub <= mre_pkg::SUBIDX_W'(CW'(r_sub_total));
            end
        end
        if (i_cmd.reject) begin
            r_res_status <= mre_pkg::ST_REJECTED;
        end
        if (i_cmd.scan_init) begin
            r_res_status <= w_is_poll ? mre_pkg::ST_NO_MATCH : mre_pkg::ST_DONE;
        end
        if (i_cmd.scan && w_hit) begin
            if (w_is_poll) begin
                r_res_status <= mre_pkg::ST_DONE;
                r_res_type   <= r_rd_type;
                r_res_pay    <= mre_pkg::WORD_W'(r_rd_pay);
            end else if (r_res_cnt != mre_pkg::COUNT_MAX) begin
                r_res_cnt <= r_res_cnt + mre_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_seq    <= r_res_seq;
            r_o_sub    <= r_res_sub;
            r_o_type   <= r_res_type;
            r_o_pay    <= r_res_pay;
            r_o_cnt    <= r_res_cnt;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_assigned_seq = r_o_seq;
    assign o_assigned_sub = r_o_sub;
    assign o_got_type     = r_o_type;
    assign o_got_payload  = r_o_pay;
    assign o_match_count  = r_o_cnt;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(RING_DEPTH))
        else $error("ring fill level above depth");

    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub_total <= STW'(MAX_SUBSCRIBERS))
        else $error("reader count above table size");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |=> r_seq == $past(r_seq) + 64'd1)
        else $error("sequence counter did not advance on publish");

    a_full_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish && w_ring_full |=> w_ring_full && (r_oldest != $past(r_oldest)))
        else $error("full ring did not drop its oldest event");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

### src/multi_reader_event_ring_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_event_ring_unit
// Event ring with overwrite-oldest storage, 64-bit sequence stamps and a
// table of filtered readers with their own cursors.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one command transaction:
// publish, subscribe, poll or count pending. The output channel
// (o_out_valid / i_out_ready) returns exactly one result transaction per
// command, in order. One command is processed at a time; a new one is taken
// while the previous result still waits in the output register.
// Publish, subscribe and a rejected reader go from execute straight to the
// result state; poll and pending first scan the ring, and a poll that
// matches ends its scan early. The next command is accepted in the cycle
// after the result is loaded. The scan reads one ring slot per cycle
// through the single registered read port of the event memory, so a poll
// or pending on a full ring visits all RING_DEPTH slots in turn, unless a
// poll matches first.
// Reset empties the ring, clears the reader table count and sets the next
// sequence number to 1; no memory clearing pass is needed. When the receiver
// stalls, the result holds in the output register and the block stops after
// finishing the next command.
// ----------------------------------------------------------------------------
module multi_reader_event_ring_unit #(
    parameter int RING_DEPTH      = 128,
    parameter int MAX_SUBSCRIBERS = 16,
    parameter int PAYLOAD_BITS    = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mre_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [mre_pkg::TYPE_W-1:0]   i_pub_type,
    input  logic [mre_pkg::WORD_W-1:0]   i_pub_payload,
    input  logic [mre_pkg::WORD_W-1:0]   i_filter_mask,
    input  logic [mre_pkg::SUBIDX_W-1:0] i_sub_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mre_pkg::STATUS_W-1:0] o_status,
    output logic [mre_pkg::SEQ_W-1:0]    o_assigned_seq,
    output logic [mre_pkg::SUBIDX_W-1:0] o_assigned_sub,
    output logic [mre_pkg::TYPE_W-1:0]   o_got_type,
    output logic [mre_pkg::WORD_W-1:0]   o_got_payload,
    output logic [mre_pkg::COUNT_W-1:0]  o_match_count
);

    mre_pkg::t_dp_cmd  w_cmd;
    mre_pkg::t_dp_stat w_stat;

    mre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mre_dp #(
        .RING_DEPTH      (RING_DEPTH),
        .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS),
        .PAYLOAD_BITS    (PAYLOAD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_opcode       (i_opcode),
        .i_pub_type     (i_pub_type),
        .i_pub_payload  (i_pub_payload),
        .i_filter_mask  (i_filter_mask),
        .i_sub_index    (i_sub_index),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_assigned_seq (o_assigned_seq),
        .o_assigned_sub (o_assigned_sub),
        .o_got_type     (o_got_type),
        .o_got_payload  (o_got_payload),
        .o_match_count  (o_match_count)
    );

endmodule
